@@ src/mnps_pkg.sv @@
// shared types and constants for the mono note priority stack
// no dependencies; read by the interfaces, the cell and the top level
`default_nettype none

package mnps_pkg;

   localparam int NOTE_W = 7;
   localparam int HELD_W = 5;

   typedef logic [NOTE_W-1:0] note_type;

   // event kind carried by each input transaction
   typedef enum logic {
      KIND_NOTE_ON  = 1'b0,
      KIND_NOTE_OFF = 1'b1
   } kind_type;

   // control broadcast from the top level to every cell
   typedef struct packed {
      logic     push;   // note on accepted this cycle
      logic     pop;    // note off accepted this cycle
      note_type key;    // note number of the event
   } cell_ctrl_type;

endpackage

`default_nettype wire

@@ src/mnps_if.sv @@
// valid/ready channel interfaces for event requests and voice-control responses
// depends on mnps_pkg
`default_nettype none

interface mnps_req_if;
   logic              valid;
   logic              ready;
   logic              kind;
   mnps_pkg::note_type note;

   modport source (output valid, output kind, output note, input ready);
   modport sink   (input valid, input kind, input note, output ready);
endinterface

interface mnps_rsp_if;
   logic                        valid;
   logic                        ready;
   mnps_pkg::note_type          pitch_note;
   logic                        pitch_update;
   logic                        env_trigger;
   logic                        env_release;
   logic                        osc_reset;
   logic [mnps_pkg::HELD_W-1:0] held_count;
   logic                        dropped;

   modport source (output valid, output pitch_note, output pitch_update,
                   output env_trigger, output env_release, output osc_reset,
                   output held_count, output dropped, input ready);
   modport sink   (input valid, input pitch_note, input pitch_update,
                   input env_trigger, input env_release, input osc_reset,
                   input held_count, input dropped, output ready);
endinterface

`default_nettype wire

@@ src/mnps_cell.sv @@
// one stack slot: holds a note, compares it to the event key and shifts
// toward or away from the top with its neighbors; depends on mnps_pkg
`default_nettype none

module mnps_cell (
   input  wire logic                    clock,
   input  wire mnps_pkg::cell_ctrl_type ctrl,
   input  wire logic                    occupied,
   input  wire logic                    hit_in,
   output logic                         hit_out,
   input  wire mnps_pkg::note_type      prev_note,
   input  wire mnps_pkg::note_type      next_note,
   output mnps_pkg::note_type           note
);

   mnps_pkg::note_type note_ff;
   mnps_pkg::note_type note_in;
   logic               match;

   assign match   = occupied && (note_ff == ctrl.key);
   assign hit_out = hit_in | match;
   assign note    = note_ff;

   // push: every slot down to the old copy moves one away from the top
   // pop: the matching slot and everything older move one toward the top
   always_comb begin
      if (ctrl.push && !hit_in) begin
         note_in = prev_note;
      end else if (ctrl.pop && hit_out) begin
         note_in = next_note;
      end else begin
         note_in = note_ff;
      end
   end

   always_ff @(posedge clock) begin
      note_ff <= note_in;
   end

endmodule

`default_nettype wire

@@ src/mono_note_priority_stack.sv @@
// top level of the monophonic last-note-priority voice controller
// depends on mnps_pkg, mnps_req_if, mnps_rsp_if and mnps_cell
`default_nettype none

// Last-note-priority voice control for a monophonic synth. Each request
// transaction is a note on or note off; each one yields exactly one response
// transaction in the cycle after it is accepted. Held notes live in a row of
// STACK_DEPTH cells, newest in cell 0 and oldest at the far end. A note on
// removes any held copy of its note and pushes it on top; when all cells are
// full and the note is new, the oldest note falls off the end and the
// response flags dropped. A note off closes the gap left by its note and the
// newest remaining note becomes the pitch; with nothing left held the
// envelopes are released and the pitch stays where it was. Throughput is one
// transaction per clock: a new request is taken in the same cycle the
// previous response is taken, and ready drops only while a response waits.
// The clock period is set by the match chain that ripples through all cells
// combinationally to find the old copy of the event's note. Reset empties the
// stack and zeroes the current pitch; no clearing pass is needed.
module mono_note_priority_stack #(
   parameter int STACK_DEPTH = 16
) (
   input wire logic  clock,
   input wire logic  reset,
   mnps_req_if.sink   req_bus,
   mnps_rsp_if.source rsp_bus
);

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int EXT_W = (CNT_W > mnps_pkg::HELD_W) ? CNT_W : mnps_pkg::HELD_W;

   // handshake
   logic accept;
   logic rsp_valid_ff;
   logic rsp_valid_in;

   // stack bookkeeping
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic [EXT_W-1:0]   count_ext;
   mnps_pkg::note_type last_pitch_ff;
   mnps_pkg::note_type last_pitch_in;
   logic               full;
   logic               found;
   logic               is_off;

   // cell row wiring
   mnps_pkg::cell_ctrl_type ctrl;
   mnps_pkg::note_type      cell_note [STACK_DEPTH];
   logic [STACK_DEPTH:0]    hit;
   logic [STACK_DEPTH-1:0]  occupied;

   // response registers
   mnps_pkg::note_type          pitch_note_ff,   pitch_note_in;
   logic                        pitch_update_ff, pitch_update_in;
   logic                        env_trigger_ff,  env_trigger_in;
   logic                        env_release_ff,  env_release_in;
   logic                        osc_reset_ff,    osc_reset_in;
   logic [mnps_pkg::HELD_W-1:0] held_count_ff,   held_count_in;
   logic                        dropped_ff,      dropped_in;

   // a new request goes in whenever the response slot is empty or draining
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign rsp_valid_in  = accept || (rsp_valid_ff && !rsp_bus.ready);

   assign is_off   = (req_bus.kind == mnps_pkg::KIND_NOTE_OFF);
   assign ctrl.push = accept && !is_off;
   assign ctrl.pop  = accept && is_off;
   assign ctrl.key  = req_bus.note;

   // match chain: hit[i] says the event's note sits in a cell nearer the top
   assign hit[0] = 1'b0;

   genvar gi;
   generate
      for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
         mnps_pkg::note_type prev_note;
         mnps_pkg::note_type next_note;

         assign occupied[gi] = (CNT_W'(gi) < count_ff);

         // the top cell takes the new note; the last cell has no older neighbor
         if (gi == 0) begin : g_top
            assign prev_note = req_bus.note;
         end else begin : g_mid
            assign prev_note = cell_note[gi-1];
         end
         if (gi == STACK_DEPTH - 1) begin : g_end
            assign next_note = cell_note[gi];
         end else begin : g_inner
            assign next_note = cell_note[gi+1];
         end

         mnps_cell u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .occupied  (occupied[gi]),
            .hit_in    (hit[gi]),
            .hit_out   (hit[gi+1]),
            .prev_note (prev_note),
            .next_note (next_note),
            .note      (cell_note[gi])
         );
      end
   endgenerate

   assign found = hit[STACK_DEPTH];
   assign full  = (count_ff == CNT_W'(STACK_DEPTH));

   // next count, pitch and response fields for the event on the request side
   always_comb begin
      pitch_update_in = 1'b0;
      env_trigger_in  = 1'b0;
      env_release_in  = 1'b0;
      osc_reset_in    = 1'b0;
      dropped_in      = 1'b0;
      last_pitch_in   = last_pitch_ff;
      count_in        = count_ff;

      if (!is_off) begin
         // a held copy just moves to the top; otherwise the stack grows
         // unless full, in which case the oldest note is lost
         if (!found && !full) begin
            count_in = count_ff + CNT_W'(1);
         end
         dropped_in      = !found && full;
         last_pitch_in   = req_bus.note;
         pitch_update_in = 1'b1;
         env_trigger_in  = 1'b1;
         osc_reset_in    = (count_in == CNT_W'(1));
      end else begin
         if (found) begin
            count_in = count_ff - CNT_W'(1);
         end
         if (count_in == '0) begin
            env_release_in = 1'b1;
         end else begin
            // newest survivor: cell 1 if the top cell held the released note
            last_pitch_in   = hit[1] ? cell_note[1] : cell_note[0];
            pitch_update_in = 1'b1;
         end
      end

      pitch_note_in = last_pitch_in;
      count_ext     = EXT_W'(count_in);
      held_count_in = count_ext[mnps_pkg::HELD_W-1:0];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         count_ff      <= '0;
         last_pitch_ff <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff      <= count_in;
            last_pitch_ff <= last_pitch_in;
         end
      end
   end

   // response payload, loaded with each accepted transaction
   always_ff @(posedge clock) begin
      if (accept) begin
         pitch_note_ff   <= pitch_note_in;
         pitch_update_ff <= pitch_update_in;
         env_trigger_ff  <= env_trigger_in;
         env_release_ff  <= env_release_in;
         osc_reset_ff    <= osc_reset_in;
         held_count_ff   <= held_count_in;
         dropped_ff      <= dropped_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.pitch_note   = pitch_note_ff;
   assign rsp_bus.pitch_update = pitch_update_ff;
   assign rsp_bus.env_trigger  = env_trigger_ff;
   assign rsp_bus.env_release  = env_release_ff;
   assign rsp_bus.osc_reset    = osc_reset_ff;
   assign rsp_bus.held_count   = held_count_ff;
   assign rsp_bus.dropped      = dropped_ff;

endmodule

`default_nettype wire
